### sv/hwk_pkg.sv
package hwk_pkg;

   localparam int TICKS_PER_SECOND_DEFAULT = 100;
   localparam int TIMEOUT_MAX = 3600;
   localparam int TIMEOUT_DEFAULT = 30;
   localparam int TMO_W = 12;
   localparam logic [7:0] MAGIC_CHAR = 8'h56;   // 'V'

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_NO_WAY_OUT = 1'b0;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BUSY = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef enum logic [2:0] {
      ACT_TICK        = 3'd0,
      ACT_OPEN        = 3'd1,
      ACT_WRITE       = 3'd2,
      ACT_CLOSE       = 3'd3,
      ACT_KEEPALIVE   = 3'd4,
      ACT_SET_TIMEOUT = 3'd5,
      ACT_SET_OPTIONS = 3'd6,
      ACT_SHUTDOWN    = 3'd7
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  byte_value;
      logic        first_byte;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic             ping_strobe;
      logic             stop_strobe;
      logic             heartbeat_lost;
      logic             unexpected_close;
      logic [1:0]       status;
      logic [TMO_W-1:0] timeout_now;
   } rsp_type;

endpackage

### sv/heartbeat_watchdog_keeper.sv
// A req transfer lands in the input register, and its result in the result register, which drives rsp_valid.
// Throughput: one item per cycle; the only limit is rsp_stall, which backs up into req_stall.
// All action logic (including the reload multiply by a constant) sits between the two registers.
// Reset (synchronous, active high): pipeline empty, timer disarmed, device closed,
// counters zero, timeout 30 s, no_way_out cleared.
module heartbeat_watchdog_keeper
   import hwk_pkg::*;
#(
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // item channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    out_free;     // result register can take a new item this cycle
   logic    fire;         // input-stage item is processed and moves to the result register
   logic    req_xfer;
   logic    no_way_out;
   rsp_type result;

   hwk_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .no_way_out (no_way_out)
   );

   hwk_core #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_data_ff),
      .no_way_out (no_way_out),
      .result     (result)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && out_free;
   // input stage only backs up when it holds an item that cannot move on
   assign req_stall = in_valid_ff && !out_free;
   assign req_xfer = req_valid && !req_stall;

   assign in_valid_in = req_xfer || (in_valid_ff && !fire);
   assign out_valid_in = out_free ? fire : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

### sv/hwk_csr.sv
module hwk_csr
   import hwk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic                  no_way_out
);

   logic no_way_out_ff;
   logic no_way_out_in;
   logic wr_hit;

   // word index sits above the byte offset
   assign wr_hit = psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == REG_NO_WAY_OUT);
   assign no_way_out_in = wr_hit ? pwdata[0] : no_way_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_way_out_ff <= 1'b0;
      end else begin
         no_way_out_ff <= no_way_out_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == REG_NO_WAY_OUT) begin
         prdata[0] = no_way_out_ff;
      end
   end

   assign pready = 1'b1;
   assign no_way_out = no_way_out_ff;

endmodule

### sv/hwk_core.sv
module hwk_core
   import hwk_pkg::*;
#(
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  logic    no_way_out,
   output rsp_type result
);

   localparam int PING_INTERVAL = TICKS_PER_SECOND / 4 + 1;
   localparam int HB_W = $clog2(TIMEOUT_MAX * TICKS_PER_SECOND + 1);
   localparam int PC_W = $clog2(PING_INTERVAL + 1);

   logic             open_ff, open_in;
   logic             armed_ff, armed_in;
   logic             magic_ff, magic_in;
   logic [HB_W-1:0]  hb_ff, hb_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [TMO_W-1:0] tmo_ff, tmo_in;

   logic [TMO_W-1:0] tmo_sel;
   logic [HB_W-1:0]  reload;
   logic [HB_W-1:0]  hb_dec;
   logic             tmo_ok;
   rsp_type          res;

   // heartbeat reload uses the new timeout on a set-timeout item
   assign tmo_sel = (item.action == ACT_SET_TIMEOUT) ? item.value[TMO_W-1:0] : tmo_ff;
   assign reload = HB_W'(32'(tmo_sel) * 32'(TICKS_PER_SECOND));
   assign hb_dec = (hb_ff != '0) ? hb_ff - HB_W'(1) : hb_ff;
   assign tmo_ok = (item.value >= 16'd1) && (item.value <= 16'(TIMEOUT_MAX));

   always_comb begin
      open_in = open_ff;
      armed_in = armed_ff;
      magic_in = magic_ff;
      hb_in = hb_ff;
      pc_in = pc_ff;
      tmo_in = tmo_ff;
      res = '0;
      res.status = STATUS_OK;
      case (item.action)
         ACT_TICK: begin
            hb_in = hb_dec;
            if (armed_ff) begin
               if (pc_ff <= PC_W'(1)) begin
                  if (hb_dec != '0) begin
                     res.ping_strobe = 1'b1;
                     pc_in = PC_W'(PING_INTERVAL);
                  end else begin
                     res.heartbeat_lost = 1'b1;
                     armed_in = 1'b0;
                     pc_in = '0;
                  end
               end else begin
                  pc_in = pc_ff - PC_W'(1);
               end
            end
         end
         ACT_OPEN: begin
            if (open_ff) begin
               res.status = STATUS_BUSY;
            end else begin
               open_in = 1'b1;
               hb_in = reload;
               pc_in = PC_W'(PING_INTERVAL);
               armed_in = 1'b1;
            end
         end
         ACT_WRITE: begin
            if (!no_way_out) begin
               if (item.byte_value == MAGIC_CHAR) begin
                  magic_in = 1'b1;
               end else if (item.first_byte) begin
                  magic_in = 1'b0;
               end
            end
            hb_in = reload;
         end
         ACT_CLOSE: begin
            res.stop_strobe = magic_ff;
            res.unexpected_close = !magic_ff;
            armed_in = 1'b0;
            open_in = 1'b0;
            magic_in = 1'b0;
         end
         ACT_KEEPALIVE: begin
            hb_in = reload;
         end
         ACT_SET_TIMEOUT: begin
            if (tmo_ok) begin
               tmo_in = item.value[TMO_W-1:0];
               hb_in = reload;
            end else begin
               res.status = STATUS_INVALID;
            end
         end
         ACT_SET_OPTIONS: begin
            if (item.value[1:0] == 2'b00) begin
               res.status = STATUS_INVALID;
            end else begin
               // disable first, then enable
               if (item.value[0]) begin
                  armed_in = 1'b0;
                  res.stop_strobe = 1'b1;
               end
               if (item.value[1]) begin
                  hb_in = reload;
                  pc_in = PC_W'(PING_INTERVAL);
                  armed_in = 1'b1;
               end
            end
         end
         ACT_SHUTDOWN: begin
            armed_in = 1'b0;
            res.stop_strobe = 1'b1;
         end
         default: begin
            res.status = STATUS_OK;
         end
      endcase
      res.timeout_now = tmo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         armed_ff <= 1'b0;
         magic_ff <= 1'b0;
         hb_ff <= '0;
         pc_ff <= '0;
         tmo_ff <= TMO_W'(TIMEOUT_DEFAULT);
      end else if (fire) begin
         open_ff <= open_in;
         armed_ff <= armed_in;
         magic_ff <= magic_in;
         hb_ff <= hb_in;
         pc_ff <= pc_in;
         tmo_ff <= tmo_in;
      end
   end

   assign result = res;

endmodule

### sv/hwk_checker.sv
module hwk_port_checker
   import hwk_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // input backs up only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // timeout stays in its legal range
   a_tmo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.timeout_now >= TMO_W'(1)) &&
                    (rsp_data.timeout_now <= TMO_W'(TIMEOUT_MAX)))
      else $error("timeout_now out of range");

   // one action raises at most one of the strobes and flags
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.ping_strobe, rsp_data.stop_strobe,
                                rsp_data.heartbeat_lost, rsp_data.unexpected_close}) <= 1)
      else $error("more than one event in one result");

endmodule

bind heartbeat_watchdog_keeper hwk_port_checker u_hwk_checker (.*);

### tb/hwk_checker.sv
module hwk_checker
   import hwk_pkg::*;
#(
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PING_INTERVAL = TICKS_PER_SECOND / 4 + 1;
   localparam logic [CSR_ADDR_W-1:0] NWO_ADDR = CSR_ADDR_W'(4 * REG_NO_WAY_OUT);

   // keeper state as seen from outside
   logic        nwo_cfg;
   logic        dev_open;
   logic        timer_on;
   logic        magic_seen;
   int unsigned beats_left;
   int unsigned ping_left;
   int unsigned tmo_secs;

   rsp_type expected_rsp[$];

   initial begin
      errors = 0;
      pending = 0;
   end

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 200)
         $display("%0t ns: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         report_mismatch(what, want, got);
   endtask

   function automatic void reload_beats();
      beats_left = tmo_secs * TICKS_PER_SECOND;
   endfunction

   function automatic void arm_keeper();
      reload_beats();
      ping_left = PING_INTERVAL;
      timer_on = 1'b1;
   endfunction

   // advances the keeper by one action, returns the response it gives
   function automatic rsp_type keeper_response(req_type it);
      rsp_type r;
      r = '0;
      case (it.action)
         ACT_TICK: begin
            if (beats_left != 0)
               beats_left--;
            if (timer_on) begin
               if (ping_left <= 1) begin
                  if (beats_left != 0) begin
                     r.ping_strobe = 1'b1;
                     ping_left = PING_INTERVAL;
                  end else begin
                     r.heartbeat_lost = 1'b1;
                     timer_on = 1'b0;
                     ping_left = 0;
                  end
               end else begin
                  ping_left--;
               end
            end
         end
         ACT_OPEN: begin
            if (dev_open) begin
               r.status = STATUS_BUSY;
            end else begin
               dev_open = 1'b1;
               arm_keeper();
            end
         end
         ACT_WRITE: begin
            if (!nwo_cfg) begin
               if (it.first_byte)
                  magic_seen = 1'b0;
               if (it.byte_value == MAGIC_CHAR)
                  magic_seen = 1'b1;
            end
            reload_beats();
         end
         ACT_CLOSE: begin
            if (magic_seen)
               r.stop_strobe = 1'b1;
            else
               r.unexpected_close = 1'b1;
            timer_on = 1'b0;
            dev_open = 1'b0;
            magic_seen = 1'b0;
         end
         ACT_KEEPALIVE: reload_beats();
         ACT_SET_TIMEOUT: begin
            if (it.value < 1 || it.value > TIMEOUT_MAX) begin
               r.status = STATUS_INVALID;
            end else begin
               tmo_secs = it.value;
               reload_beats();
            end
         end
         ACT_SET_OPTIONS: begin
            if (it.value[1:0] == 2'b00) begin
               r.status = STATUS_INVALID;
            end else begin
               if (it.value[0]) begin
                  timer_on = 1'b0;
                  r.stop_strobe = 1'b1;
               end
               if (it.value[1])
                  arm_keeper();
            end
         end
         default: begin
            timer_on = 1'b0;
            r.stop_strobe = 1'b1;
         end
      endcase
      r.timeout_now = tmo_secs[TMO_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         nwo_cfg = 1'b0;
         dev_open = 1'b0;
         timer_on = 1'b0;
         magic_seen = 1'b0;
         beats_left = 0;
         ping_left = 0;
         tmo_secs = TIMEOUT_DEFAULT;
         expected_rsp.delete();
      end else begin
         if (psel && penable && pready && paddr == NWO_ADDR) begin
            if (pwrite)
               nwo_cfg = pwdata[0];
            else
               check_field("no_way_out readback", 32'(nwo_cfg), 32'(prdata[0]));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected result", 32'h0, 32'(rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               check_field("ping_strobe", 32'(want.ping_strobe), 32'(rsp_data.ping_strobe));
               check_field("stop_strobe", 32'(want.stop_strobe), 32'(rsp_data.stop_strobe));
               check_field("heartbeat_lost", 32'(want.heartbeat_lost),
                           32'(rsp_data.heartbeat_lost));
               check_field("unexpected_close", 32'(want.unexpected_close),
                           32'(rsp_data.unexpected_close));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("timeout_now", 32'(want.timeout_now), 32'(rsp_data.timeout_now));
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(keeper_response(req_data));
      end
      pending <= expected_rsp.size();
   end

endmodule

### tb/tb_top.sv
module tb_top;
   import hwk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICKS = TICKS_PER_SECOND_DEFAULT;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 140;          // about 1050 transfers in all, with scenario overrun
   localparam int CYCLE_LIMIT = 400000;       // far above the slowest legal run
   localparam logic [CSR_ADDR_W-1:0] NWO_ADDR = CSR_ADDR_W'(4 * REG_NO_WAY_OUT);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int          checker_errors;
   int          pending;
   int          gap_pct = 0;      // chance per cycle that the sender holds off
   int          stall_pct = 0;    // chance per cycle that the receiver stalls
   int          phase_items;
   int unsigned cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   heartbeat_watchdog_keeper #(
      .TICKS_PER_SECOND (TICKS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   hwk_checker #(
      .TICKS_PER_SECOND (TICKS)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .errors    (checker_errors),
      .pending   (pending)
   );

   // Receiver side: stall drawn fresh every cycle, independent of anything else.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   // Hard stop in case the block hangs or loses a transfer.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // One register access: setup cycle, access cycle, then psel drops before the task returns, so
   // that back-to-back accesses never touch psel twice in one step.
   task automatic csr_access(logic wr, logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= NWO_ADDR;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sender side: random hold-off before valid goes up, then hold the payload
   // until the transfer happens. Valid stays high after a transfer so the next
   // item can follow back to back without a second assignment in one step.
   task automatic send_item(req_type it);
      while ($urandom_range(99, 0) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      phase_items++;
   endtask

   // Drop valid and wait until every predicted result has come back, then wait on
   // to cover the two-stage pipeline.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type pack_item(action_type a, logic [7:0] b, logic f,
                                         logic [15:0] v);
      req_type it;
      it.action = a;
      it.byte_value = b;
      it.first_byte = f;
      it.value = v;
      return it;
   endfunction

   // Random fields for a given action, biased toward the interesting corners:
   // the magic close byte, small timeouts (short heartbeats) and the bounds.
   function automatic req_type shaped_item(action_type a);
      req_type it;
      int      k;
      it.action = a;
      it.byte_value = ($urandom_range(99, 0) < 35) ? MAGIC_CHAR : 8'($urandom);
      it.first_byte = 1'($urandom_range(1, 0));
      it.value = 16'($urandom);
      k = $urandom_range(99, 0);
      case (a)
         ACT_SET_TIMEOUT: begin
            if (k < 70)
               it.value = 16'($urandom_range(3, 1));
            else if (k < 80)
               it.value = 16'($urandom_range(TIMEOUT_MAX, 1));
            else if (k < 90)
               case ($urandom_range(2, 0))
                  0: it.value = 16'd0;
                  1: it.value = 16'(TIMEOUT_MAX);
                  default: it.value = 16'(TIMEOUT_MAX + 1);
               endcase
         end
         ACT_SET_OPTIONS: begin
            if (k < 60)
               it.value[1:0] = 2'($urandom_range(3, 1));
         end
         default: ;
      endcase
      return it;
   endfunction

   function automatic action_type session_action();
      int k;
      k = $urandom_range(99, 0);
      if (k < 50) return ACT_TICK;
      if (k < 75) return ACT_WRITE;
      if (k < 83) return ACT_KEEPALIVE;
      if (k < 90) return ACT_SET_TIMEOUT;
      if (k < 95) return ACT_SET_OPTIONS;
      if (k < 98) return ACT_SHUTDOWN;
      return ACT_OPEN;
   endfunction

   // A random stretch of stimulus:
   //   session - open, a mix of writes, ticks, keepalives and other actions, mostly a close
   //   rundown - 1 s timeout, arm, then enough bare ticks to ping and often
   //             to let the heartbeat run out
   //   noise   - a few fully random actions
   task automatic run_scenario();
      int k;
      int n;
      k = $urandom_range(99, 0);
      if (k < 60) begin
         n = $urandom_range(24, 4);
         send_item(shaped_item(ACT_OPEN));
         repeat (n) send_item(shaped_item(session_action()));
         if ($urandom_range(99, 0) < 75)
            send_item(shaped_item(ACT_CLOSE));
      end else if (k < 70) begin
         n = $urandom_range(130, 80);
         send_item(pack_item(ACT_SET_TIMEOUT, 8'($urandom), 1'($urandom), 16'd1));
         send_item(pack_item(ACT_SET_OPTIONS, 8'($urandom), 1'($urandom), 16'd2));
         repeat (n) send_item(shaped_item(ACT_TICK));
         if ($urandom_range(1, 0) == 1)
            send_item(shaped_item(ACT_CLOSE));
      end else begin
         n = $urandom_range(6, 1);
         repeat (n) send_item(shaped_item(action_type'($urandom_range(7, 0))));
      end
   endtask

   initial begin
      int     gap_plan[PHASES] = '{0, 85, 0, 6, 85, 0};
      int     stall_plan[PHASES] = '{0, 0, 85, 6, 0, 85};
      logic   paused;

      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(1'b1, 32'd0);
      csr_access(1'b0, 32'd0);

      // Directed corners, back to back with no idling.
      send_item(pack_item(ACT_TICK, 8'h00, 1'b0, 16'h0000));           // closed, nothing armed
      send_item(pack_item(ACT_KEEPALIVE, 8'hFF, 1'b1, 16'hFFFF));      // reload while closed
      send_item(pack_item(ACT_WRITE, MAGIC_CHAR, 1'b1, 16'h0000));     // write while closed
      send_item(pack_item(ACT_OPEN, 8'h00, 1'b0, 16'h0000));
      send_item(pack_item(ACT_OPEN, 8'h00, 1'b0, 16'h0000));           // busy
      send_item(pack_item(ACT_WRITE, 8'h41, 1'b1, 16'h0000));          // new call clears magic
      send_item(pack_item(ACT_WRITE, MAGIC_CHAR, 1'b0, 16'h0000));
      send_item(pack_item(ACT_WRITE, 8'hFF, 1'b0, 16'h0000));          // keeps magic
      send_item(pack_item(ACT_CLOSE, 8'h00, 1'b0, 16'h0000));          // clean stop
      send_item(pack_item(ACT_CLOSE, 8'h00, 1'b0, 16'h0000));          // close while closed
      send_item(pack_item(ACT_SET_TIMEOUT, 8'h00, 1'b0, 16'd0));       // below range
      send_item(pack_item(ACT_SET_TIMEOUT, 8'h00, 1'b0, 16'(TIMEOUT_MAX + 1)));
      send_item(pack_item(ACT_SET_TIMEOUT, 8'h00, 1'b0, 16'hFFFF));
      send_item(pack_item(ACT_SET_TIMEOUT, 8'h00, 1'b0, 16'(TIMEOUT_MAX)));
      send_item(pack_item(ACT_SET_TIMEOUT, 8'h00, 1'b0, 16'd1));
      send_item(pack_item(ACT_SET_OPTIONS, 8'h00, 1'b0, 16'h0000));    // no option bit
      send_item(pack_item(ACT_SET_OPTIONS, 8'h00, 1'b0, 16'hFFFC));    // high bits only
      send_item(pack_item(ACT_SET_OPTIONS, 8'h00, 1'b0, 16'h0001));    // disable
      send_item(pack_item(ACT_SET_OPTIONS, 8'h00, 1'b0, 16'h0002));    // enable
      send_item(pack_item(ACT_SET_OPTIONS, 8'h00, 1'b0, 16'h0003));    // disable then enable
      send_item(pack_item(ACT_SHUTDOWN, 8'h00, 1'b0, 16'h0000));
      send_item(pack_item(ACT_WRITE, 8'h00, 1'b1, 16'h0000));
      send_item(pack_item(ACT_TICK, 8'hFF, 1'b1, 16'hFFFF));
      wait_drained();

      // Random phases: each sets no_way_out (alternating, junk in the upper
      // bits) while the block is idle, then runs with its own idle pattern.
      for (int ph = 0; ph < PHASES; ph++) begin
         csr_access(1'b1, {31'($urandom), 1'(ph % 2)});
         csr_access(1'b0, 32'd0);
         gap_pct = gap_plan[ph];
         stall_pct = stall_plan[ph];
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            run_scenario();
            // sender holds off once until the pipeline has fully drained
            if (ph == 1 && !paused && phase_items >= PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
         wait_drained();
      end

      gap_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (checker_errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
